### rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// a condition that must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// a cause that must be followed by an effect on the next edge
`define ASSERT_NEXT(label, clk, rst_n, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);
`endif

### rtl/aes128d_pkg.sv
// types, tables and round functions for aes-128 decryption
package aes128d_pkg;

    localparam int NumRounds = 10;
    localparam int KeyWidth  = 128;

    typedef struct packed {
        logic [63:0] cipher_hi;
        logic [63:0] cipher_lo;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] plain_hi;
        logic [63:0] plain_lo;
    } t_out_beat;

    typedef enum logic [1:0] {
        REG_KEY_HI   = 2'd0,
        REG_KEY_LO   = 2'd1,
        REG_KEY_LAST = 2'd2
    } t_reg_idx;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // byte i of a 128-bit word, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
        return w[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
        logic [7:0] b [16];
        logic [127:0] r;
        for (int i = 0; i < 16; i++) b[i] = get_byte(k, i);
        b[0] = b[0] ^ SBOX[b[13]] ^ rc;
        b[1] = b[1] ^ SBOX[b[14]];
        b[2] = b[2] ^ SBOX[b[15]];
        b[3] = b[3] ^ SBOX[b[12]];
        for (int i = 4; i < 16; i++) b[i] = b[i] ^ b[i-4];
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = b[i];
        return r;
    endfunction

    function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [7:0] rc);
        logic [7:0] b [16];
        logic [127:0] r;
        for (int i = 0; i < 16; i++) b[i] = get_byte(k, i);
        for (int i = 15; i >= 4; i--) b[i] = b[i] ^ b[i-4];
        b[0] = b[0] ^ SBOX[b[13]] ^ rc;
        b[1] = b[1] ^ SBOX[b[14]];
        b[2] = b[2] ^ SBOX[b[15]];
        b[3] = b[3] ^ SBOX[b[12]];
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = b[i];
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] r;
        for (int c = 0; c < 4; c++)
            for (int q = 0; q < 4; q++)
                r[127-8*(4*c+q) -: 8] = INV_SBOX[get_byte(s, 4*((c-q+4)%4)+q)];
        return r;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int q = 0; q < 4; q++) begin
                a[q]  = get_byte(s, 4*c+q);
                x2[q] = xt(a[q]);
                x4[q] = xt(x2[q]);
                x8[q] = xt(x4[q]);
                m9[q] = x8[q] ^ a[q];
                mb[q] = x8[q] ^ x2[q] ^ a[q];
                md[q] = x8[q] ^ x4[q] ^ a[q];
                me[q] = x8[q] ^ x4[q] ^ x2[q];
            end
            r[127-8*(4*c)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
            r[127-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
            r[127-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
            r[127-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
        end
        return r;
    endfunction

endpackage

### rtl/aes128d_keysched.sv
// round key table: forward expansion and reverse schedule, one round per cycle
module aes128d_keysched (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [1:0]                      i_idx,
    input  logic [63:0]                     i_data,
    output logic [aes128d_pkg::NumRounds:0][127:0] o_rk,
    output logic                            o_busy
);
    import aes128d_pkg::*;

    typedef enum logic [1:0] {S_FWD, S_BWD, S_DONE} t_state;

    t_state       r_state;
    logic [127:0] r_key;
    logic         r_last;
    logic [127:0] r_work;
    logic [3:0]   r_cnt;
    logic [NumRounds:0][127:0] r_rk;

    // any write restarts the expansion; blocks are only fed once it settles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FWD;
            r_key   <= '0;
            r_last  <= 1'b0;
            r_cnt   <= '0;
            r_work  <= '0;
        end else if (i_we) begin
            unique case (i_idx)
                REG_KEY_HI:   r_key[127:64] <= i_data;
                REG_KEY_LO:   r_key[63:0]   <= i_data;
                REG_KEY_LAST: r_last        <= i_data[0];
                default: ;
            endcase
            r_state <= S_FWD;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_FWD: begin
                    if (r_cnt == 4'd0) r_work <= r_key;
                    else r_work <= key_fwd(r_work, RCON[r_cnt - 4'd1]);
                    if (r_last || r_cnt == 4'(NumRounds)) begin
                        r_state <= S_BWD;
                        r_cnt   <= 4'(NumRounds);
                        if (r_last) r_rk[NumRounds] <= r_key;
                        else r_rk[NumRounds] <= key_fwd(r_work, RCON[NumRounds-1]);
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_BWD: begin
                    r_rk[r_cnt - 4'd1] <= key_bwd(r_rk[r_cnt], RCON[r_cnt - 4'd1]);
                    if (r_cnt == 4'd1) r_state <= S_DONE;
                    r_cnt <= r_cnt - 4'd1;
                end
                S_DONE: ;
                default: r_state <= S_FWD;
            endcase
        end
    end

    assign o_rk   = r_rk;
    assign o_busy = (r_state != S_DONE);
endmodule

### rtl/aes128d_round.sv
// one inverse round pipeline stage with its own valid and payload register
module aes128d_round #(
    parameter bit LastRound = 1'b0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [127:0] i_state,
    input  logic [127:0] i_rk,
    output logic         o_valid,
    output logic [127:0] o_state
);
    import aes128d_pkg::*;

    logic [127:0] n_state;
    logic         r_valid;
    logic [127:0] r_state;

    always_comb begin
        n_state = inv_shift_sub(i_state) ^ i_rk;
        if (!LastRound) n_state = inv_mix(n_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_state <= n_state;
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
endmodule

### rtl/aes128_block_decrypt.sv
// aes-128 decryption top level: key schedule plus eleven-stage round pipeline
// an input beat passes the entry register (initial key add), then one stage per round, before output valid
// throughput: one block per cycle while the output is not stalled and the key schedule is not busy
// after reset or any key write the schedule runs forward then reverse, input stalled
// reset is synchronous, active low, and clears the key registers to zero
module aes128_block_decrypt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  aes128d_pkg::t_in_beat   i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output aes128d_pkg::t_out_beat  o_data,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [63:0]             i_cfg_data
);
    import aes128d_pkg::*;
    `include "assert_macros.svh"

    logic [NumRounds:0][127:0] rk;
    logic                      busy;
    logic                      en;
    logic                      r_v0;
    logic [127:0]              r_s0;
    logic [NumRounds:0]        v;
    logic [NumRounds:0][127:0] s;

    aes128d_keysched u_ks (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_rk   (rk),
        .o_busy (busy)
    );

    // whole pipeline advances unless the output beat is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en || busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_s0 <= {i_data.cipher_hi, i_data.cipher_lo} ^ rk[NumRounds];
    end

    assign v[0] = r_v0;
    assign s[0] = r_s0;

    for (genvar g = 0; g < NumRounds; g++) begin : g_rnd
        aes128d_round #(.LastRound(g == NumRounds - 1)) u_rnd (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(v[g]),
            .i_state(s[g]),
            .i_rk   (rk[NumRounds - 1 - g]),
            .o_valid(v[g+1]),
            .o_state(s[g+1])
        );
    end

    assign o_valid = v[NumRounds];
    assign o_data  = {s[NumRounds][127:64], s[NumRounds][63:0]};

    `ASSERT_ALWAYS(a_no_accept_busy, i_clk, i_rst_n, !(busy && !o_stall), "accept during key setup")
    `ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data), "output beat dropped")
    `ASSERT_NEXT(a_entry, i_clk, i_rst_n, i_valid && !o_stall, r_v0, "accepted beat lost")
endmodule

### bench/aes128_block_decrypt_tb.sv
// testbench for aes128_block_decrypt: directed and random blocks against a local aes-128 model
module aes128_block_decrypt_tb;
    import aes128d_pkg::*;

    localparam int WatchdogLimit = 4000;
    localparam int DrainCycles = 30;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in_beat i_data;
    logic o_valid;
    logic i_stall;
    t_out_beat o_data;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [63:0] i_cfg_data;

    aes128_block_decrypt u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // model copy of the key registers
    logic [63:0] mdl_key_hi;
    logic [63:0] mdl_key_lo;
    logic mdl_key_last;

    t_out_beat plain_queue[$];
    int fail_count = 0;
    int idle_cycles = 0;
    int beats_in = 0;
    int beats_out = 0;
    int settings_used = 0;
    bit quiet_mode = 0;

    logic [7:0] fwd_tab [256];
    logic [7:0] inv_tab [256];
    logic [7:0] rc_tab [10];

    initial begin
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] x;
        // build the s-box from the field inverse and affine map
        for (int a = 0; a < 256; a++) begin
            q = 8'h00;
            for (int b = 1; b < 256; b++)
                if (gf_mul(a[7:0], b[7:0]) == 8'h01) q = b[7:0];
            x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
                ^ {q[3:0], q[7:4]} ^ 8'h63;
            fwd_tab[a] = x;
        end
        for (int a = 0; a < 256; a++) inv_tab[fwd_tab[a]] = a[7:0];
        p = 8'h01;
        for (int r = 0; r < 10; r++) begin
            rc_tab[r] = p;
            p = gf_mul(p, 8'h02);
        end
    end

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic void step_key(ref logic [7:0] k [16], input logic [7:0] rc,
                                     input bit back);
        if (back) for (int i = 15; i >= 4; i--) k[i] = k[i] ^ k[i-4];
        k[0] = k[0] ^ fwd_tab[k[13]] ^ rc;
        k[1] = k[1] ^ fwd_tab[k[14]];
        k[2] = k[2] ^ fwd_tab[k[15]];
        k[3] = k[3] ^ fwd_tab[k[12]];
        if (!back) for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i-4];
    endfunction

    function automatic t_out_beat decrypt_block(input t_in_beat c);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] k [16];
        logic [127:0] cw;
        logic [127:0] kw;
        t_out_beat res;
        cw = c;
        kw = {mdl_key_hi, mdl_key_lo};
        for (int i = 0; i < 16; i++) begin
            s[i] = cw[127-8*i -: 8];
            k[i] = kw[127-8*i -: 8];
        end
        if (!mdl_key_last) for (int r = 0; r < 10; r++) step_key(k, rc_tab[r], 1'b0);
        for (int i = 0; i < 16; i++) s[i] = s[i] ^ k[i];
        for (int r = 10; r >= 1; r--) begin
            step_key(k, rc_tab[r-1], 1'b1);
            for (int col = 0; col < 4; col++)
                for (int row = 0; row < 4; row++)
                    t[4*col+row] = inv_tab[s[4*((col-row+4)%4)+row]];
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[i];
            if (r > 1) begin
                for (int col = 0; col < 4; col++) begin
                    t[0] = s[4*col]; t[1] = s[4*col+1]; t[2] = s[4*col+2]; t[3] = s[4*col+3];
                    s[4*col]   = gf_mul(t[0], 8'd14) ^ gf_mul(t[1], 8'd11)
                                 ^ gf_mul(t[2], 8'd13) ^ gf_mul(t[3], 8'd9);
                    s[4*col+1] = gf_mul(t[0], 8'd9) ^ gf_mul(t[1], 8'd14)
                                 ^ gf_mul(t[2], 8'd11) ^ gf_mul(t[3], 8'd13);
                    s[4*col+2] = gf_mul(t[0], 8'd13) ^ gf_mul(t[1], 8'd9)
                                 ^ gf_mul(t[2], 8'd14) ^ gf_mul(t[3], 8'd11);
                    s[4*col+3] = gf_mul(t[0], 8'd11) ^ gf_mul(t[1], 8'd13)
                                 ^ gf_mul(t[2], 8'd9) ^ gf_mul(t[3], 8'd14);
                end
            end
        end
        for (int i = 0; i < 16; i++) cw[127-8*i -: 8] = s[i];
        res = cw;
        return res;
    endfunction

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // output side: random stall, check each accepted beat
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            i_stall <= 1'b1;
        end else begin
            if (o_valid && !i_stall) begin
                beats_out++;
                if (plain_queue.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    want = plain_queue.pop_front();
                    if (o_data.plain_hi !== want.plain_hi) begin
                        $error("plain_hi expected %h got %h", want.plain_hi, o_data.plain_hi);
                        fail_count++;
                    end
                    if (o_data.plain_lo !== want.plain_lo) begin
                        $error("plain_lo expected %h got %h", want.plain_lo, o_data.plain_lo);
                        fail_count++;
                    end
                end
            end
            i_stall <= !quiet_mode && ($urandom_range(99) < 9);
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no progress for %0d cycles", WatchdogLimit);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        t_in_beat beat;
        beat.cipher_hi = hi;
        beat.cipher_lo = lo;
        while (!quiet_mode && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= beat;
        plain_queue.push_back(decrypt_block(beat));
        beats_in++;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (plain_queue.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_KEY_HI: mdl_key_hi = val;
            REG_KEY_LO: mdl_key_lo = val;
            default: mdl_key_last = val[0];
        endcase
    endtask

    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo, input bit last);
        wait_drained();
        write_reg(REG_KEY_HI, hi);
        write_reg(REG_KEY_LO, lo);
        write_reg(REG_KEY_LAST, {63'd0, last});
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_block({$urandom, $urandom}, {$urandom, $urandom});
    endtask

    task automatic test_reset_key();
        // key all zero after reset
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_random(4);
    endtask

    task automatic test_known_vector();
        // standard example: key 000102..0f, plaintext 00112233..ff
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 0);
        send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'h8000000000000000, 64'h1);
    endtask

    task automatic test_last_round_key();
        load_key(64'h13111d7fe3944a17, 64'hf307a78b4d2b30c5, 1);
        send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(64'hffffffff00000000, 64'h00000000ffffffff);
        load_key('1, '1, 1);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        load_key('1, '1, 0);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block('1, '1);
    endtask

    task automatic test_random_keys();
        for (int ph = 0; ph < 8; ph++) begin
            load_key({$urandom, $urandom}, {$urandom, $urandom}, ph[0]);
            if (ph == 3) begin
                // back-to-back beats with no stalls
                quiet_mode = 1;
                send_random(40);
                quiet_mode = 0;
            end else begin
                send_random(40);
            end
            if (ph == 5) begin
                // hold off until every result is back
                i_valid <= 1'b0;
                while (plain_queue.size() != 0) @(posedge i_clk);
                send_random(10);
            end
        end
        load_key(64'h0, 64'h0, 0);
        send_random(40);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_KEY_HI;
        i_cfg_data = '0;
        mdl_key_hi = '0;
        mdl_key_lo = '0;
        mdl_key_last = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_key();
        test_known_vector();
        test_last_round_key();
        test_random_keys();
        wait_drained();
        $display("covered %0d blocks in, %0d out, over %0d key settings", beats_in,
                 beats_out, settings_used);
        $display("both key modes with zero, all-ones, known and random keys");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
